### rtl/core/triangle_mean_color_top_macros.svh
// assertion macros for the triangle mean color block
// expects clk and rst_n in the scope of the module that includes it
`ifndef TRIANGLE_MEAN_COLOR_TOP_MACROS_SVH
`define TRIANGLE_MEAN_COLOR_TOP_MACROS_SVH

// same-cycle implication
`define TMC_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tmc_pkg.sv
// shared constants, types and helper functions for the triangle mean color block
// no dependencies
`default_nettype none

package tmc_pkg;

  localparam int FIELD_W        = 12;
  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_W        = 8;
  localparam int SUM_W          = 32;
  localparam int TALLY_W        = 25;
  localparam int DIFF_W         = FIELD_W + 1;
  localparam int PROD_W         = 2 * DIFF_W;
  localparam int NCH            = 3;
  localparam int MUL_STEPS      = 6;
  localparam int CFG_IDX_W      = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [FIELD_W-1:0]         coord_t;
  typedef logic [COLOR_W-1:0]         color_t;
  typedef logic [SUM_W-1:0]           sum_t;
  typedef logic [TALLY_W-1:0]         tally_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic [NCH-1:0][SUM_W-1:0]  chan_sums_t;
  typedef logic [NCH-1:0][COLOR_W-1:0] chan_means_t;

  localparam cfg_idx_t REG_VA_X = 3'd0;
  localparam cfg_idx_t REG_VA_Y = 3'd1;
  localparam cfg_idx_t REG_VB_X = 3'd2;
  localparam cfg_idx_t REG_VB_Y = 3'd3;
  localparam cfg_idx_t REG_VC_X = 3'd4;
  localparam cfg_idx_t REG_VC_Y = 3'd5;

  typedef struct packed {
    logic  valid;
    logic  second;
    diff_t a;
    diff_t b;
  } mac_req_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic pos;
  } mac_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic diff_t cdiff(coord_t u, coord_t v);
    return $signed({1'b0, u}) - $signed({1'b0, v});
  endfunction

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic sum_t sat_add(sum_t s, color_t v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(v);
    return t[SUM_W] ? '1 : t[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/tmc_mac.sv
// shared multiplier with product register and edge-value subtract
// depends on tmc_pkg
`default_nettype none

module tmc_mac (
  input  wire              clk,
  input  wire              rst_n,
  input  tmc_pkg::mac_req_t req,
  output tmc_pkg::mac_rsp_t rsp
);
  import tmc_pkg::*;

  logic                     pvalid_r;
  logic                     psecond_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] first_r;
  logic signed [PROD_W:0]   edge_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r  <= 1'b0;
      psecond_r <= 1'b0;
    end else begin
      pvalid_r  <= req.valid;
      psecond_r <= req.second;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
    if (pvalid_r && !psecond_r) begin
      first_r <= prod_r;
    end
  end

  assign edge_val  = {first_r[PROD_W-1], first_r} - {prod_r[PROD_W-1], prod_r};
  assign rsp.valid = pvalid_r & psecond_r;
  assign rsp.neg   = edge_val[PROD_W];
  assign rsp.pos   = !edge_val[PROD_W] && (edge_val != '0);

endmodule

`default_nettype wire

### rtl/core/tmc_div.sv
// iterative divider, one compare-subtract per cycle, clamps quotients at 255
// depends on tmc_pkg
`default_nettype none

module tmc_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  tmc_pkg::chan_sums_t   dividend,
  input  tmc_pkg::tally_t       divisor,
  output tmc_pkg::div_status_t  status,
  output tmc_pkg::chan_means_t  quot
);
  import tmc_pkg::*;

  localparam int DIVW = SUM_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [1:0]        ch_r;
  logic [3:0]        k_r;
  sum_t              rem_r;
  color_t            q_r;
  chan_means_t       quot_r;
  logic [DIVW-1:0]   shifted;
  logic [DIVW-1:0]   diff;
  logic              ge;
  logic              clamp;
  logic              chan_end;
  logic              last_ch;
  logic [1:0]        ch_next;
  color_t            q_set;

  assign shifted  = DIVW'(divisor) << k_r;
  assign ge       = {2'b00, rem_r} >= shifted;
  assign diff     = {2'b00, rem_r} - shifted;
  assign clamp    = (k_r == 4'(COLOR_W)) && ge;
  assign chan_end = clamp || (k_r == 4'd0);
  assign last_ch  = (ch_r == 2'(NCH-1));
  assign ch_next  = ch_r + 2'd1;
  assign q_set    = q_r | (COLOR_W'(ge) << k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ch_r   <= 2'd0;
      k_r    <= 4'(COLOR_W);
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ch_r   <= 2'd0;
        k_r    <= 4'(COLOR_W);
      end else if (busy_r) begin
        if (chan_end) begin
          if (last_ch) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            ch_r <= ch_next;
            k_r  <= 4'(COLOR_W);
          end
        end else begin
          k_r <= k_r - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[0];
      q_r   <= '0;
    end else if (busy_r) begin
      if (chan_end) begin
        quot_r[ch_r] <= clamp ? '1 : q_set;
        q_r          <= '0;
        if (!last_ch) begin
          rem_r <= dividend[ch_next];
        end
      end else begin
        q_r <= q_set;
        if (ge) begin
          rem_r <= diff[SUM_W-1:0];
        end
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quot        = quot_r;

endmodule

`default_nettype wire

### rtl/core/triangle_mean_color_top.sv
// triangle mean color: coverage test, running sums and per-channel means
// depends on tmc_pkg, tmc_mac, tmc_div and triangle_mean_color_top_macros.svh
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | pixel position, colors, last marker
//   out     | output    | out_valid/out_ready | three means, count, empty flag
//   cfg     | input     | cfg_valid/cfg_ready | register index and vertex coordinate
//
// a pixel is taken in, then six products go through the one multiplier, then
// its product register drains and the sums update; a last pixel then passes
// through the divider channel by channel and then loads the result register
// reset is synchronous and clears vertices, sums and count; cfg_ready is always high
// a waiting result holds the block before the next result is loaded, not before input
`default_nettype none
`include "triangle_mean_color_top_macros.svh"

module triangle_mean_color_top #(
  parameter int COORD_BITS = tmc_pkg::COORD_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [tmc_pkg::FIELD_W-1:0] in_pixel_x,
  input  wire  [tmc_pkg::FIELD_W-1:0] in_pixel_y,
  input  wire  [tmc_pkg::COLOR_W-1:0] in_red_in,
  input  wire  [tmc_pkg::COLOR_W-1:0] in_green_in,
  input  wire  [tmc_pkg::COLOR_W-1:0] in_blue_in,
  input  wire                        in_last_pixel,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [tmc_pkg::COLOR_W-1:0] out_mean_red,
  output logic [tmc_pkg::COLOR_W-1:0] out_mean_green,
  output logic [tmc_pkg::COLOR_W-1:0] out_mean_blue,
  output logic [tmc_pkg::TALLY_W-1:0] out_covered_count,
  output logic                       out_empty_flag,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [tmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [tmc_pkg::FIELD_W-1:0] cfg_data
);
  import tmc_pkg::*;

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EDGE   = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    mstep_r;
  logic          neg_r, pos_r;
  logic [CW-1:0] vax_r, vay_r, vbx_r, vby_r, vcx_r, vcy_r;
  logic [CW-1:0] px_r, py_r;
  color_t        red_r, green_r, blue_r;
  logic          last_r;
  sum_t          red_sum_r, green_sum_r, blue_sum_r;
  sum_t          red_sum_nxt, green_sum_nxt, blue_sum_nxt;
  tally_t        tally_r, tally_nxt;
  logic          out_valid_r;
  color_t        out_red_r, out_green_r, out_blue_r;
  tally_t        out_count_r;
  logic          out_empty_r;

  mac_req_t      mac_req;
  mac_rsp_t      mac_rsp;
  div_status_t   div_st;
  chan_means_t   div_quot;
  chan_sums_t    div_dividend;
  logic          div_start;

  logic          in_acc;
  logic          edge_done;
  logic          out_free;
  logic          neg_all, pos_all;
  logic          in_box;
  logic          covered;
  logic [1:0]    eidx;
  coord_t        ax, ay, bx, by, pxw, pyw;
  coord_t        vxa, vya, vxb, vyb, vxc, vyc;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign edge_done = (state_r == ST_EDGE) && (mstep_r == 3'(MUL_STEPS));
  assign out_free  = !out_valid_r || out_ready;

  // vertex registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vax_r <= '0;
      vay_r <= '0;
      vbx_r <= '0;
      vby_r <= '0;
      vcx_r <= '0;
      vcy_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VA_X: vax_r <= cfg_data[CW-1:0];
        REG_VA_Y: vay_r <= cfg_data[CW-1:0];
        REG_VB_X: vbx_r <= cfg_data[CW-1:0];
        REG_VB_Y: vby_r <= cfg_data[CW-1:0];
        REG_VC_X: vcx_r <= cfg_data[CW-1:0];
        REG_VC_Y: vcy_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // pixel capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r    <= in_pixel_x[CW-1:0];
      py_r    <= in_pixel_y[CW-1:0];
      red_r   <= in_red_in;
      green_r <= in_green_in;
      blue_r  <= in_blue_in;
      last_r  <= in_last_pixel;
    end
  end

  assign vxa = coord_t'(vax_r);
  assign vya = coord_t'(vay_r);
  assign vxb = coord_t'(vbx_r);
  assign vyb = coord_t'(vby_r);
  assign vxc = coord_t'(vcx_r);
  assign vyc = coord_t'(vcy_r);
  assign pxw = coord_t'(px_r);
  assign pyw = coord_t'(py_r);

  // operand select for the shared multiplier
  assign eidx = mstep_r[2:1];

  always_comb begin
    unique case (eidx)
      2'd0: begin
        ax = vxa; ay = vya; bx = vxb; by = vyb;
      end
      2'd1: begin
        ax = vxb; ay = vyb; bx = vxc; by = vyc;
      end
      default: begin
        ax = vxc; ay = vyc; bx = vxa; by = vya;
      end
    endcase
  end

  always_comb begin
    mac_req.valid  = (state_r == ST_EDGE) && (mstep_r < 3'(MUL_STEPS));
    mac_req.second = mstep_r[0];
    mac_req.a      = mstep_r[0] ? cdiff(ax, bx) : cdiff(pxw, bx);
    mac_req.b      = mstep_r[0] ? cdiff(pyw, by) : cdiff(ay, by);
  end

  tmc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  // coverage decision
  assign neg_all = neg_r || (mac_rsp.valid && mac_rsp.neg);
  assign pos_all = pos_r || (mac_rsp.valid && mac_rsp.pos);
  assign in_box  = (pxw >= min3(vxa, vxb, vxc)) && (pxw <= max3(vxa, vxb, vxc)) &&
                   (pyw >= min3(vya, vyb, vyc)) && (pyw <= max3(vya, vyb, vyc));
  assign covered = in_box && !(neg_all && pos_all);

  always_comb begin
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    tally_nxt     = tally_r;
    if (edge_done && covered) begin
      red_sum_nxt   = sat_add(red_sum_r, red_r);
      green_sum_nxt = sat_add(green_sum_r, green_r);
      blue_sum_nxt  = sat_add(blue_sum_r, blue_r);
      if (tally_r != '1) begin
        tally_nxt = tally_r + 1'b1;
      end
    end else if ((state_r == ST_RESULT) && out_free) begin
      red_sum_nxt   = '0;
      green_sum_nxt = '0;
      blue_sum_nxt  = '0;
      tally_nxt     = '0;
    end
  end

  // divider
  assign div_start = edge_done && last_r;

  always_comb begin
    div_dividend[CH_RED]   = red_sum_nxt;
    div_dividend[CH_GREEN] = green_sum_nxt;
    div_dividend[CH_BLUE]  = blue_sum_nxt;
  end

  tmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (tally_nxt),
    .status   (div_st),
    .quot     (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_EDGE;
      ST_EDGE:   if (edge_done) state_nxt = last_r ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (div_st.done) state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= 3'd0;
      neg_r       <= 1'b0;
      pos_r       <= 1'b0;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      tally_r     <= tally_nxt;
      if (in_acc) begin
        mstep_r <= 3'd0;
        neg_r   <= 1'b0;
        pos_r   <= 1'b0;
      end else if (state_r == ST_EDGE) begin
        mstep_r <= mstep_r + 3'd1;
        neg_r   <= neg_all;
        pos_r   <= pos_all;
      end
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state_r == ST_RESULT) && out_free) begin
      out_empty_r <= (tally_r == '0);
      out_count_r <= tally_r;
      out_red_r   <= (tally_r == '0) ? '0 : div_quot[CH_RED];
      out_green_r <= (tally_r == '0) ? '0 : div_quot[CH_GREEN];
      out_blue_r  <= (tally_r == '0) ? '0 : div_quot[CH_BLUE];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_red      = out_red_r;
  assign out_mean_green    = out_green_r;
  assign out_mean_blue     = out_blue_r;
  assign out_covered_count = out_count_r;
  assign out_empty_flag    = out_empty_r;

  `TMC_CHECK(a_div_in_divide, div_st.busy, state_r == ST_DIVIDE, "divider busy outside divide")
  `TMC_CHECK(a_sums_clear, tally_r == '0, red_sum_r == '0 && green_sum_r == '0 && blue_sum_r == '0, "sums nonzero with zero count")
  `TMC_CHECK(a_empty_result, out_valid_r && out_empty_r, out_count_r == '0 && out_red_r == '0 && out_green_r == '0 && out_blue_r == '0, "empty result not zero")
  `TMC_CHECK_NEXT(a_accept_start, in_valid && in_ready, state_r == ST_EDGE && mstep_r == 3'd0, "pixel transaction did not start edge pass")

endmodule

`default_nettype wire
